// ===== design/scpf_pkg.sv =====
`default_nettype none
package scpf_pkg;

   // Command codes carried in the operation field
   typedef enum logic [2:0] {
      OP_MOVE       = 3'd0,
      OP_READ       = 3'd1,
      OP_PASSIVE    = 3'd2,
      OP_POWER_DOWN = 3'd3,
      OP_ROTATE     = 3'd4,
      OP_SET        = 3'd5,
      OP_SYNC_START = 3'd6,
      OP_SYNC_TGT   = 3'd7
   } op_type;

   localparam logic [2:0] DIR_CCW = 3'd3;
   localparam logic [2:0] DIR_CW  = 3'd4;

   localparam logic [7:0] PKT_HEADER    = 8'hff;
   localparam logic [7:0] CSUM_MASK     = 8'h7f;
   localparam logic [7:0] READ_BASE     = 8'ha0;
   localparam logic [7:0] PASSIVE_BASE  = 8'hc0;
   localparam logic [7:0] PASSIVE_ARG   = 8'h10;
   localparam logic [7:0] PDOWN_CMD     = 8'hdf;
   localparam logic [7:0] PDOWN_ARG     = 8'h20;
   localparam logic [7:0] SYNC_ID_ALL   = 8'h1f;
   localparam logic [2:0] ROTATE_MODE   = 3'd6;
   localparam logic [2:0] SET_MODE      = 3'd7;

   localparam int PKT_BYTES       = 6;
   localparam int PKT_CNT_W       = 3;
   localparam int MAX_SYNC_SERVOS = 31;
   localparam int QUEUE_DEPTH     = 4;

   typedef struct packed {
      op_type     operation;
      logic [4:0] servo_id;
      logic [3:0] level;
      logic [7:0] position;
      logic [2:0] direction;
      logic [7:0] sub_code;
      logic [7:0] value_a;
      logic [7:0] value_b;
      logic [4:0] last_id;
      logic [7:0] target_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       end_of_run;
   } rsp_type;

   // One framed packet: bytes in send order and how many are used
   typedef struct packed {
      logic [PKT_BYTES-1:0][7:0] bytes;
      logic [PKT_CNT_W-1:0]      count;
   } pkt_type;

endpackage
`default_nettype wire

// ===== design/scpf_front.sv =====
`default_nettype none
module scpf_front #(
   parameter int MAX_SYNC_SERVOS = scpf_pkg::MAX_SYNC_SERVOS
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    accept,
   input  scpf_pkg::req_type      req_item,
   output logic                   pkt_push,
   output scpf_pkg::pkt_type      pkt
);

   localparam logic [5:0] MAX_CNT = 6'(MAX_SYNC_SERVOS);

   logic [4:0] sync_left_ff, sync_left_in;
   logic [7:0] sync_sum_ff, sync_sum_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_left_ff <= '0;
         sync_sum_ff  <= '0;
      end else if (accept) begin
         sync_left_ff <= sync_left_in;
         sync_sum_ff  <= sync_sum_in;
      end
   end

   always_comb begin
      logic [7:0] byte_a;
      logic [7:0] byte_b;
      logic [7:0] sum_next;
      logic [4:0] left_next;
      logic [5:0] cnt_wide;
      logic [4:0] cnt;
      byte_a       = '0;
      byte_b       = '0;
      sum_next     = sync_sum_ff ^ req_item.target_byte;
      left_next    = sync_left_ff - 5'd1;
      cnt_wide     = {1'b0, req_item.last_id} + 6'd1;
      cnt          = (cnt_wide > MAX_CNT) ? MAX_CNT[4:0] : cnt_wide[4:0];
      pkt          = '0;
      pkt_push     = 1'b0;
      sync_left_in = '0;
      sync_sum_in  = '0;
      pkt.bytes[0] = scpf_pkg::PKT_HEADER;
      unique case (req_item.operation)
         scpf_pkg::OP_MOVE: begin
            byte_a   = {req_item.level[2:0], req_item.servo_id};
            byte_b   = req_item.position;
            pkt_push = 1'b1;
         end
         scpf_pkg::OP_READ: begin
            byte_a   = scpf_pkg::READ_BASE | {3'b000, req_item.servo_id};
            byte_b   = '0;
            pkt_push = 1'b1;
         end
         scpf_pkg::OP_PASSIVE: begin
            byte_a   = scpf_pkg::PASSIVE_BASE | {3'b000, req_item.servo_id};
            byte_b   = scpf_pkg::PASSIVE_ARG;
            pkt_push = 1'b1;
         end
         scpf_pkg::OP_POWER_DOWN: begin
            byte_a   = scpf_pkg::PDOWN_CMD;
            byte_b   = scpf_pkg::PDOWN_ARG;
            pkt_push = 1'b1;
         end
         scpf_pkg::OP_ROTATE: begin
            byte_a   = {scpf_pkg::ROTATE_MODE, req_item.servo_id};
            byte_b   = {1'b0, req_item.direction, req_item.level};
            // drop rotations with a direction that means nothing
            pkt_push = (req_item.direction == scpf_pkg::DIR_CCW) ||
                       (req_item.direction == scpf_pkg::DIR_CW);
         end
         scpf_pkg::OP_SET: begin
            pkt_push     = 1'b1;
            pkt.bytes[1] = {scpf_pkg::SET_MODE, req_item.servo_id};
            pkt.bytes[2] = req_item.sub_code;
            pkt.bytes[3] = req_item.value_a;
            pkt.bytes[4] = req_item.value_b;
            pkt.bytes[5] = (pkt.bytes[1] ^ pkt.bytes[2] ^ pkt.bytes[3] ^ pkt.bytes[4])
                           & scpf_pkg::CSUM_MASK;
            pkt.count    = 3'd6;
         end
         scpf_pkg::OP_SYNC_START: begin
            pkt_push     = 1'b1;
            pkt.bytes[1] = {req_item.level[2:0], 5'b00000} | scpf_pkg::SYNC_ID_ALL;
            pkt.bytes[2] = {3'b000, cnt};
            pkt.count    = 3'd3;
            sync_left_in = cnt;
         end
         scpf_pkg::OP_SYNC_TGT: begin
            // stray targets with no sync open send nothing and keep state
            if (sync_left_ff != '0) begin
               pkt_push     = 1'b1;
               pkt.bytes[0] = req_item.target_byte;
               sync_left_in = left_next;
               if (left_next != '0) begin
                  pkt.count   = 3'd1;
                  sync_sum_in = sum_next;
               end else begin
                  pkt.bytes[1] = sum_next & scpf_pkg::CSUM_MASK;
                  pkt.count    = 3'd2;
               end
            end
         end
      endcase
      if (req_item.operation inside {scpf_pkg::OP_MOVE, scpf_pkg::OP_READ,
                                     scpf_pkg::OP_PASSIVE, scpf_pkg::OP_POWER_DOWN,
                                     scpf_pkg::OP_ROTATE}) begin
         pkt.bytes[1] = byte_a;
         pkt.bytes[2] = byte_b;
         pkt.bytes[3] = (byte_a ^ byte_b) & scpf_pkg::CSUM_MASK;
         pkt.count    = 3'd4;
      end
      pkt_push = pkt_push && accept;
   end

endmodule
`default_nettype wire

// ===== design/scpf_queue.sv =====
`default_nettype none
module scpf_queue #(
   parameter int QUEUE_DEPTH = scpf_pkg::QUEUE_DEPTH
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                q_push,
   input  scpf_pkg::pkt_type  q_wdata,
   output logic               q_full,
   input  wire                q_pop,
   output logic               q_empty,
   output scpf_pkg::pkt_type  q_rdata
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   scpf_pkg::pkt_type slots_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic do_push, do_pop;

   assign q_full  = (fill_ff == FULL_CNT);
   assign q_empty = (fill_ff == '0);
   assign q_rdata = slots_ff[rd_ptr_ff];
   assign do_push = q_push && !q_full;
   assign do_pop  = q_pop && !q_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop)      fill_in = fill_ff + 1'b1;
      else if (do_pop && !do_push) fill_in = fill_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slots_ff[wr_ptr_ff] <= q_wdata;
   end

endmodule
`default_nettype wire

// ===== design/scpf_back.sv =====
`default_nettype none
module scpf_back (
   input  wire                clock,
   input  wire                reset,
   input  wire                q_empty,
   input  scpf_pkg::pkt_type  q_rdata,
   output logic               q_pop,
   output logic               empty,
   input  wire                pop,
   output scpf_pkg::rsp_type  rsp_item
);

   scpf_pkg::pkt_type cur_ff, cur_in;
   logic [scpf_pkg::PKT_CNT_W-1:0] idx_ff, idx_in;
   logic busy_ff, busy_in;
   logic out_valid_ff, out_valid_in;
   scpf_pkg::rsp_type out_ff, out_in;
   logic advance, last_byte;

   assign empty    = !out_valid_ff;
   assign rsp_item = out_ff;

   always_comb begin
      advance      = busy_ff && (!out_valid_ff || pop);
      last_byte    = (idx_ff == cur_ff.count - 1'b1);
      q_pop        = !q_empty && (!busy_ff || (advance && last_byte));
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !pop;
      cur_in       = cur_ff;
      idx_in       = idx_ff;
      busy_in      = busy_ff;
      if (advance) begin
         out_in.tx_byte    = cur_ff.bytes[idx_ff];
         out_in.end_of_run = last_byte;
         out_valid_in      = 1'b1;
         idx_in            = idx_ff + 1'b1;
         if (last_byte) busy_in = 1'b0;
      end
      if (q_pop) begin
         cur_in  = q_rdata;
         idx_in  = '0;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      out_ff <= out_in;
   end

endmodule
`default_nettype wire

// ===== design/servo_command_packet_framer.sv =====
`default_nettype none
// channel   ports                            direction  moves
// ------    -------------------------------  ---------  ------------------------------
// request   push, full, req_item             in         one command item per accept
// response  empty, pop, rsp_item             out        one packet byte per item
//
// A command is accepted in any cycle the packet queue has room; framing and sync
// state update in that same cycle, so commands may arrive back to back.
// Bytes leave one per cycle from the output register while pop is held, and a
// command yields 1 to 6 bytes, none for dropped ones.
// A stalled pop holds the byte in place; the queue absorbs QUEUE_DEPTH packets
// before full rises. Reset clears sync state, queue and the output valid flag.
module servo_command_packet_framer #(
   parameter int MAX_SYNC_SERVOS = scpf_pkg::MAX_SYNC_SERVOS,
   parameter int QUEUE_DEPTH     = scpf_pkg::QUEUE_DEPTH
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                push,
   output logic               full,
   input  scpf_pkg::req_type  req_item,
   output logic               empty,
   input  wire                pop,
   output scpf_pkg::rsp_type  rsp_item
);

   logic              accept;
   logic              pkt_push;
   scpf_pkg::pkt_type pkt;
   logic              q_empty;
   logic              q_pop;
   scpf_pkg::pkt_type q_rdata;

   // accept only while the queue has room for a whole packet
   assign accept = push && !full;

   // frame the command and track the open sync
   scpf_front #(
      .MAX_SYNC_SERVOS(MAX_SYNC_SERVOS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_item (req_item),
      .pkt_push (pkt_push),
      .pkt      (pkt)
   );

   // hold framed packets between front and serializer
   scpf_queue #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (pkt_push),
      .q_wdata (pkt),
      .q_full  (full),
      .q_pop   (q_pop),
      .q_empty (q_empty),
      .q_rdata (q_rdata)
   );

   // advance through the packet bytes, marking the last one
   scpf_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_rdata  (q_rdata),
      .q_pop    (q_pop),
      .empty    (empty),
      .pop      (pop),
      .rsp_item (rsp_item)
   );

endmodule
`default_nettype wire
